// File: hw/rtl/bbff_pkg.sv
// Shared types and constants for the border background flood fill block.
// Used by bbff_cell and border_background_flood_fill_top; no dependencies.
package bbff_pkg;

    localparam int unsigned ROW_W  = 64;
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned SIZE_W = 7;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd32;
    localparam logic [2:0] ADDR_IMAGE_SIZE = 3'd0;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] transparent_mask;
        logic             last_row;
    } t_result;

    // Per-cycle commands broadcast to every row cell.
    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             pix_open;
        logic             seed;
        logic             fill;
        logic             shift;
    } t_cell_ctl;

    // Frame geometry derived from the image size register.
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [IDX_W-1:0]  last_idx;
        logic [ROW_W-1:0]  col_mask;
        logic [ROW_W-1:0]  edge_cols;
    } t_cell_cfg;

endpackage

// File: hw/rtl/border_background_flood_fill_top.sv
// Top level of the border background flood fill block: control, config port, cell chain.
// Depends on bbff_pkg and bbff_cell.
//
// Usage: write image_size (byte address 0) over the APB-style port while the block is
// idle; a write also drops any partial image. Pixels of an n x n frame enter in raster
// order, one transfer per cycle, at each edge where start is high and busy is low.
// The transfer of the last pixel starts the fill; busy stays high through it.
// Each row has a cell that holds its open and background bits and trades background
// bits with its two neighbors. A seed step loads the edge seeds, then each fill cycle spreads
// the background one pixel up, down, left and right until no cell changes; how long the
// fill runs is set by the longest open path from the edge.
// Then n result transfers follow on consecutive cycles, rows in ascending order, each
// marked by o_result_valid for one cycle, the last with last_row set. The rows shift
// up the chain to cell 0 for readout. A new frame can start on the cycle after the
// last row leaves the chain. Results cannot be stalled. Reset sets image_size to 32
// (or MAX_SIZE if smaller) and clears the counters and background rows.
module border_background_flood_fill_top #(
    parameter int unsigned MAX_SIZE = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bbff_pkg::t_pixel   i_pixel,
    output logic               o_result_valid,
    output bbff_pkg::t_result  o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bbff_pkg::*;

    localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(MAX_SIZE);
    localparam logic [SIZE_W-1:0] SIZE_INIT = (SIZE_RESET > SIZE_MAX) ? SIZE_MAX : SIZE_RESET;

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_SEED = 4'b0010,
        S_FILL = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state             r_state;
    logic [SIZE_W-1:0]  r_size;
    logic [IDX_W-1:0]   r_row;
    logic [IDX_W-1:0]   r_col;
    logic [IDX_W-1:0]   r_emit;
    logic               r_out_valid;
    t_result            r_out;
    logic [SIZE_W-1:0]  n_size;

    t_cell_ctl          w_ctl;
    t_cell_cfg          w_cfg;
    logic               w_accept;
    logic               w_cfg_wr;
    logic               w_last_col;
    logic               w_last_pix;
    logic               w_any_change;
    logic [ROW_W-1:0]   w_bg  [MAX_SIZE];
    logic [MAX_SIZE-1:0] w_chg;

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_IMAGE_SIZE) ? {{(32 - SIZE_W){1'b0}}, r_size} : '0;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_IMAGE_SIZE);

    always_comb begin
        n_size = pwdata[SIZE_W-1:0];
        if (n_size == '0) begin
            n_size = SIZE_W'(1);
        end else if (n_size > SIZE_MAX) begin
            n_size = SIZE_MAX;
        end
    end

    assign busy     = (r_state != S_LOAD);
    assign w_accept = start && !busy;

    assign w_cfg.size      = r_size;
    assign w_cfg.last_idx  = IDX_W'(r_size - SIZE_W'(1));
    assign w_cfg.col_mask  = r_size[IDX_W] ? '1 : ((ROW_W'(1) << r_size[IDX_W-1:0]) - ROW_W'(1));
    assign w_cfg.edge_cols = ROW_W'(1) | (ROW_W'(1) << w_cfg.last_idx);

    assign w_last_col = (r_col == w_cfg.last_idx);
    assign w_last_pix = w_last_col && (r_row == w_cfg.last_idx);

    assign w_ctl.load     = w_accept;
    assign w_ctl.row      = r_row;
    assign w_ctl.col      = r_col;
    assign w_ctl.pix_open = |{i_pixel.red, i_pixel.green, i_pixel.blue};
    assign w_ctl.seed     = (r_state == S_SEED);
    assign w_ctl.fill     = (r_state == S_FILL);
    assign w_ctl.shift    = (r_state == S_EMIT);

    assign w_any_change = |w_chg;

    for (genvar g = 0; g < MAX_SIZE; g++) begin : g_cell
        logic [ROW_W-1:0] w_up;
        logic [ROW_W-1:0] w_dn;
        if (g == 0) begin : g_top
            assign w_up = '0;
        end else begin : g_mid_up
            assign w_up = w_bg[g-1];
        end
        if (g == MAX_SIZE - 1) begin : g_bottom
            assign w_dn = '0;
        end else begin : g_mid_dn
            assign w_dn = w_bg[g+1];
        end
        bbff_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_cfg    (w_cfg),
            .i_bg_up  (w_up),
            .i_bg_dn  (w_dn),
            .o_bg     (w_bg[g]),
            .o_changed(w_chg[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_size      <= SIZE_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (w_cfg_wr) begin
                r_size <= n_size;
                r_row  <= '0;
                r_col  <= '0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_last_pix) begin
                            r_row   <= '0;
                            r_col   <= '0;
                            r_state <= S_SEED;
                        end else if (w_last_col) begin
                            r_col <= '0;
                            r_row <= r_row + IDX_W'(1);
                        end else begin
                            r_col <= r_col + IDX_W'(1);
                        end
                    end
                end
                S_SEED: begin
                    r_state <= S_FILL;
                end
                S_FILL: begin
                    // The change flags are registered, so one quiet pass confirms the end.
                    if (!w_any_change) begin
                        r_emit  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_emit      <= r_emit + IDX_W'(1);
                    if (r_emit == w_cfg.last_idx) begin
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT) begin
            r_out.row_index        <= r_emit;
            r_out.transparent_mask <= w_bg[0];
            r_out.last_row         <= (r_emit == w_cfg.last_idx);
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

// File: hw/rtl/bbff_cell.sv
// One row cell of the flood fill chain: holds the open and background bits of a row.
// Exchanges its background row with the cells above and below. Depends on bbff_pkg.
module bbff_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bbff_pkg::t_cell_ctl       i_ctl,
    input  bbff_pkg::t_cell_cfg       i_cfg,
    input  logic [bbff_pkg::ROW_W-1:0] i_bg_up,
    input  logic [bbff_pkg::ROW_W-1:0] i_bg_dn,
    output logic [bbff_pkg::ROW_W-1:0] o_bg,
    output logic                      o_changed
);
    import bbff_pkg::*;

    localparam logic [SIZE_W-1:0] ROW_ID = SIZE_W'(IDX);

    logic [ROW_W-1:0] r_open;
    logic [ROW_W-1:0] r_bg;
    logic             r_changed;
    logic [ROW_W-1:0] n_bg;
    logic [ROW_W-1:0] w_reach;
    logic [ROW_W-1:0] w_seed;
    logic             w_active;
    logic             w_edge_row;

    assign w_active   = ROW_ID < i_cfg.size;
    assign w_edge_row = (ROW_ID == '0) || (ROW_ID[IDX_W-1:0] == i_cfg.last_idx);
    assign w_seed     = w_edge_row ? i_cfg.col_mask : i_cfg.edge_cols;
    assign w_reach    = r_bg | (r_bg << 1) | (r_bg >> 1) | i_bg_up | i_bg_dn;
    assign n_bg       = w_active ? (r_bg | (r_open & i_cfg.col_mask & w_reach)) : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_ctl.row == ROW_ID[IDX_W-1:0])) begin
            r_open[i_ctl.col] <= i_ctl.pix_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg      <= '0;
            r_changed <= 1'b0;
        end else if (i_ctl.seed) begin
            r_bg      <= w_active ? (r_open & i_cfg.col_mask & w_seed) : '0;
            r_changed <= 1'b1;
        end else if (i_ctl.fill) begin
            r_bg      <= n_bg;
            r_changed <= (n_bg != r_bg);
        end else if (i_ctl.shift) begin
            // During readout the rows move up one cell per cycle toward cell 0.
            r_bg      <= i_bg_dn;
            r_changed <= 1'b0;
        end
    end

    assign o_bg      = r_bg;
    assign o_changed = r_changed;

endmodule
